// ----- design/ntoe_pkg.sv -----
// ----------------------------------------------------------------------------
// Node table package
// Shared entry layout, request mode codes and constants for the node table.
// ----------------------------------------------------------------------------
package ntoe_pkg;

  localparam logic [1:0] MODE_OBSERVE = 2'd0;
  localparam logic [1:0] MODE_CLEAR   = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam int unsigned NODE_TAG_MIN_LEN = 5;

  typedef struct packed {
    logic [47:0] address;
    logic [7:0]  signal;
    logic [31:0] last_seen;
    logic [31:0] packets;
    logic [15:0] node_tag;
  } entry_t;

endpackage

// ----- design/ntoe_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ntoe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ntoe_scan.sv -----
// ----------------------------------------------------------------------------
// Node table scan unit
// Compares one stored entry per cycle, while sample_i is set, against the request address and keeps
// the first match and the entry with the oldest last-seen time.
// ----------------------------------------------------------------------------
module ntoe_scan #(
  parameter int IDX_W = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 sample_i,
  input  logic [IDX_W-1:0]     index_i,
  input  ntoe_pkg::entry_t     entry_i,
  input  logic [47:0]          key_i,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output ntoe_pkg::entry_t     hit_entry_o,
  output logic [IDX_W-1:0]     old_idx_o
);

  import ntoe_pkg::*;

  logic             hit_q;
  logic             has_old_q;
  logic [IDX_W-1:0] hit_idx_q;
  entry_t           hit_entry_q;
  logic [IDX_W-1:0] old_idx_q;
  logic [31:0]      old_time_q;
  logic             match;
  logic             older;

  assign match = sample_i && !hit_q && (entry_i.address == key_i);
  assign older = sample_i && (!has_old_q || (entry_i.last_seen < old_time_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      has_old_q <= 1'b0;
    end else if (start_i) begin
      hit_q     <= 1'b0;
      has_old_q <= 1'b0;
    end else begin
      if (match) begin
        hit_q <= 1'b1;
      end
      if (older) begin
        has_old_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      hit_idx_q   <= index_i;
      hit_entry_q <= entry_i;
    end
    if (older) begin
      old_idx_q  <= index_i;
      old_time_q <= entry_i.last_seen;
    end
  end

  assign hit_o       = hit_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_entry_o = hit_entry_q;
  assign old_idx_o   = old_idx_q;

endmodule

// ----- design/node_table_oldest_eviction.sv -----
// ----------------------------------------------------------------------------
// Node table with oldest-entry eviction
// Learns radio nodes by address, tracks signal, time, packet counts and short
// ids, and replaces the least recently seen node when the table is full.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   --------  ---------  ------------------------  ------------------------------
//   request   in         in_valid_i / in_stall_o   mode, address, signal, time,
//                                                  length, destination, index
//   result    out        out_valid_o / out_stall_i slot, flags, entry, counts
//
// An observe request on a non-empty table first scans every filled entry: the scan
// reads one table entry per cycle through the single RAM read port and the shared
// compare unit. An observe on an empty table, and the clear, read and unused
// modes, go straight from the idle state to the finish state.
// Reset clears the fill count and the packet total; table contents are not
// cleared and are never shown before they are written.
// A stalled result holds the finishing request; a new request is accepted
// while a result still waits at the output.
// ----------------------------------------------------------------------------
module node_table_oldest_eviction #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [47:0]        node_address_i,
  input  logic signed [7:0]  signal_level_i,
  input  logic [31:0]        time_ms_i,
  input  logic [7:0]         packet_length_i,
  input  logic [15:0]        destination_id_i,
  input  logic [3:0]         read_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         slot_o,
  output logic               was_hit_o,
  output logic               was_evicted_o,
  output logic               entry_valid_o,
  output logic [47:0]        entry_address_o,
  output logic signed [7:0]  entry_signal_o,
  output logic [31:0]        entry_last_seen_o,
  output logic [31:0]        entry_packets_o,
  output logic [15:0]        entry_short_id_o,
  output logic [4:0]         fill_count_o,
  output logic [31:0]        total_packets_o
);

  import ntoe_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [1:0]    mode_q, mode_d;
  logic [47:0]   key_q, key_d;
  logic [7:0]    signal_q, signal_d;
  logic [31:0]   time_q, time_d;
  logic [7:0]    len_q, len_d;
  logic [15:0]   dest_q, dest_d;
  logic [3:0]    ridx_q, ridx_d;
  logic          rd_ok_q, rd_ok_d;
  logic [CW-1:0] used_q, used_d;
  logic [31:0]   total_q, total_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          cmp_v_q, cmp_v_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          out_valid_q, out_valid_d;
  logic [3:0]    slot_q, slot_d;
  logic          hit_q, hit_d;
  logic          evict_q, evict_d;
  logic          valid_q, valid_d;
  entry_t        entry_q, entry_d;
  logic [4:0]    fill_q, fill_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_entry;

  logic          scan_start;
  logic          scan_hit;
  logic [IW-1:0] scan_hit_idx;
  entry_t        scan_hit_entry;
  logic [IW-1:0] scan_old_idx;

  logic          accept;
  logic          rd_ok_now;
  logic          scan_more;
  logic          finish_go;
  logic          full;
  logic [IW-1:0] wr_idx;
  entry_t        new_e;

  assign rd_entry   = entry_t'(ram_rdata);
  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign rd_ok_now  = 32'(read_index_i) < 32'(used_q);
  assign scan_more  = scan_q < used_q;
  assign scan_start = accept;
  assign finish_go  = (state_q == ST_FINISH) && !(out_valid_q && out_stall_i);
  assign full       = used_q == CW'(TABLE_DEPTH);

  ntoe_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ntoe_scan #(
    .IDX_W (IW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .sample_i    (cmp_v_q),
    .index_i     (cmp_idx_q),
    .entry_i     (rd_entry),
    .key_i       (key_q),
    .hit_o       (scan_hit),
    .hit_idx_o   (scan_hit_idx),
    .hit_entry_o (scan_hit_entry),
    .old_idx_o   (scan_old_idx)
  );

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = IW'(scan_q);
    if (accept && (mode_i == MODE_READ) && rd_ok_now) begin
      ram_re    = 1'b1;
      ram_raddr = IW'(read_index_i);
    end else if ((state_q == ST_SCAN) && scan_more) begin
      ram_re = 1'b1;
    end
  end

  always_comb begin
    new_e = '0;
    if (scan_hit) begin
      wr_idx         = scan_hit_idx;
      new_e.packets  = scan_hit_entry.packets + 32'd1;
      new_e.node_tag = scan_hit_entry.node_tag;
    end else begin
      wr_idx        = full ? scan_old_idx : IW'(used_q);
      new_e.packets = 32'd1;
    end
    new_e.address   = key_q;
    new_e.signal    = signal_q;
    new_e.last_seen = time_q;
    if (len_q >= 8'(NODE_TAG_MIN_LEN)) begin
      new_e.node_tag = dest_q;
    end
  end

  assign ram_we    = finish_go && (mode_q == MODE_OBSERVE);
  assign ram_waddr = wr_idx;
  assign ram_wdata = new_e;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    signal_d    = signal_q;
    time_d      = time_q;
    len_d       = len_q;
    dest_d      = dest_q;
    ridx_d      = ridx_q;
    rd_ok_d     = rd_ok_q;
    used_d      = used_q;
    total_d     = total_q;
    scan_d      = scan_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    slot_d      = slot_q;
    hit_d       = hit_q;
    evict_d     = evict_q;
    valid_d     = valid_q;
    entry_d     = entry_q;
    fill_d      = fill_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_i;
          key_d    = node_address_i;
          signal_d = signal_level_i;
          time_d   = time_ms_i;
          len_d    = packet_length_i;
          dest_d   = destination_id_i;
          ridx_d   = read_index_i;
          rd_ok_d  = rd_ok_now;
          scan_d   = '0;
          if ((mode_i == MODE_OBSERVE) && (used_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_more) begin
          scan_d    = scan_q + CW'(1);
          cmp_v_d   = 1'b1;
          cmp_idx_d = IW'(scan_q);
        end
        if (cmp_v_q && (CW'(cmp_idx_q) == used_q - CW'(1))) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          slot_d      = '0;
          hit_d       = 1'b0;
          evict_d     = 1'b0;
          valid_d     = 1'b0;
          entry_d     = '0;
          unique case (mode_q)
            MODE_OBSERVE: begin
              total_d = total_q + 32'd1;
              if (!scan_hit && !full) begin
                used_d = used_q + CW'(1);
              end
              slot_d  = 4'(wr_idx);
              hit_d   = scan_hit;
              evict_d = !scan_hit && full;
              valid_d = 1'b1;
              entry_d = new_e;
            end
            MODE_CLEAR: begin
              used_d = '0;
            end
            MODE_READ: begin
              slot_d  = ridx_q;
              valid_d = rd_ok_q;
              if (rd_ok_q) begin
                entry_d = rd_entry;
              end
            end
            default: begin
            end
          endcase
          fill_d = 5'(used_d);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      total_q     <= '0;
      scan_q      <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      total_q     <= total_d;
      scan_q      <= scan_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    key_q     <= key_d;
    signal_q  <= signal_d;
    time_q    <= time_d;
    len_q     <= len_d;
    dest_q    <= dest_d;
    ridx_q    <= ridx_d;
    rd_ok_q   <= rd_ok_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    hit_q     <= hit_d;
    evict_q   <= evict_d;
    valid_q   <= valid_d;
    entry_q   <= entry_d;
    fill_q    <= fill_d;
  end

  assign in_stall_o        = state_q != ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign slot_o            = slot_q;
  assign was_hit_o         = hit_q;
  assign was_evicted_o     = evict_q;
  assign entry_valid_o     = valid_q;
  assign entry_address_o   = entry_q.address;
  assign entry_signal_o    = signed'(entry_q.signal);
  assign entry_last_seen_o = entry_q.last_seen;
  assign entry_packets_o   = entry_q.packets;
  assign entry_short_id_o  = entry_q.node_tag;
  assign fill_count_o      = fill_q;
  assign total_packets_o   = total_q;

  // The fill count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // An eviction is only reported for a miss on a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && evict_q) |-> (!hit_q && (fill_q == 5'(TABLE_DEPTH))))
    else $error("eviction reported without a full table");

  // A finished request waits while the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && out_valid_q && out_stall_i) |=> (state_q == ST_FINISH))
    else $error("result overwritten while stalled");

  // The packet total moves by at most one per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> (total_q == $past(total_q) + 32'd1))
    else $error("packet total jumped");

endmodule

// ----- dv/tb_node_table_oldest_eviction.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node table testbench
// Sends observe, clear and read requests through the valid/stall handshake,
// predicts every result from a behavioral copy of the table and compares each
// result field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_node_table_oldest_eviction;
  import ntoe_pkg::*;

  localparam int NODE_SLOTS = 16;
  localparam int POOL_SIZE = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 500;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] address;
    logic [7:0]  signal;
    logic [31:0] time_ms;
    logic [7:0]  length;
    logic [15:0] destination;
    logic [3:0]  read_index;
  } node_req_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        was_hit;
    logic        was_evicted;
    logic        entry_valid;
    entry_t      entry;
    logic [4:0]  fill_count;
    logic [31:0] total_packets;
  } node_outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = MODE_OBSERVE;
  logic [47:0]        node_address_i = '0;
  logic signed [7:0]  signal_level_i = '0;
  logic [31:0]        time_ms_i = '0;
  logic [7:0]         packet_length_i = '0;
  logic [15:0]        destination_id_i = '0;
  logic [3:0]         read_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [3:0]         slot_o;
  logic               was_hit_o;
  logic               was_evicted_o;
  logic               entry_valid_o;
  logic [47:0]        entry_address_o;
  logic signed [7:0]  entry_signal_o;
  logic [31:0]        entry_last_seen_o;
  logic [31:0]        entry_packets_o;
  logic [15:0]        entry_short_id_o;
  logic [4:0]         fill_count_o;
  logic [31:0]        total_packets_o;

  node_req_t     queued_requests[$];
  node_outcome_t predicted_outcomes[$];
  node_req_t     next_req;
  node_req_t     taken_req;
  node_outcome_t got_outcome;

  entry_t        node_entries[NODE_SLOTS];
  int            fill_used = 0;
  logic [31:0]   packets_seen = '0;

  logic [47:0]   node_pool[POOL_SIZE];
  logic [31:0]   now_ms = '0;
  logic          req_taken = 1'b0;
  logic          hold_off = 1'b0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            fail_count = 0;
  int            cycle_count = 0;

  node_table_oldest_eviction #(
    .TABLE_DEPTH(NODE_SLOTS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .node_address_i   (node_address_i),
    .signal_level_i   (signal_level_i),
    .time_ms_i        (time_ms_i),
    .packet_length_i  (packet_length_i),
    .destination_id_i (destination_id_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .slot_o           (slot_o),
    .was_hit_o        (was_hit_o),
    .was_evicted_o    (was_evicted_o),
    .entry_valid_o    (entry_valid_o),
    .entry_address_o  (entry_address_o),
    .entry_signal_o   (entry_signal_o),
    .entry_last_seen_o(entry_last_seen_o),
    .entry_packets_o  (entry_packets_o),
    .entry_short_id_o (entry_short_id_o),
    .fill_count_o     (fill_count_o),
    .total_packets_o  (total_packets_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic node_outcome_t predict_table_outcome(input node_req_t rq);
    node_outcome_t rs;
    logic          found;
    int            idx;
    rs = '0;
    found = 1'b0;
    idx = 0;
    case (rq.mode)
      MODE_OBSERVE: begin
        for (int i = 0; i < fill_used; i++) begin
          if (!found && node_entries[i].address == rq.address) begin
            found = 1'b1;
            idx = i;
          end
        end
        if (!found) begin
          if (fill_used < NODE_SLOTS) begin
            idx = fill_used;
            fill_used++;
          end else begin
            // The oldest time stamp loses its slot; ties go to the lowest index.
            for (int i = 1; i < NODE_SLOTS; i++) begin
              if (node_entries[i].last_seen < node_entries[idx].last_seen) begin
                idx = i;
              end
            end
            rs.was_evicted = 1'b1;
          end
          node_entries[idx].address = rq.address;
          node_entries[idx].packets = '0;
          node_entries[idx].node_tag = '0;
        end
        packets_seen = packets_seen + 32'd1;
        node_entries[idx].signal = rq.signal;
        node_entries[idx].last_seen = rq.time_ms;
        node_entries[idx].packets = node_entries[idx].packets + 32'd1;
        if (rq.length >= NODE_TAG_MIN_LEN) begin
          node_entries[idx].node_tag = rq.destination;
        end
        rs.slot = idx[3:0];
        rs.was_hit = found;
        rs.entry_valid = 1'b1;
        rs.entry = node_entries[idx];
      end
      MODE_CLEAR: begin
        fill_used = 0;
      end
      MODE_READ: begin
        rs.slot = rq.read_index;
        if (int'(rq.read_index) < fill_used) begin
          rs.entry_valid = 1'b1;
          rs.entry = node_entries[rq.read_index];
        end
      end
      default: begin
      end
    endcase
    rs.fill_count = fill_used[4:0];
    rs.total_packets = packets_seen;
    return rs;
  endfunction

  function automatic node_req_t make_req(input logic [1:0] mode, input logic [47:0] address,
                                         input logic [7:0] signal, input logic [31:0] time_ms,
                                         input logic [7:0] length, input logic [15:0] destination,
                                         input logic [3:0] read_index);
    node_req_t rq;
    rq.mode = mode;
    rq.address = address;
    rq.signal = signal;
    rq.time_ms = time_ms;
    rq.length = length;
    rq.destination = destination;
    rq.read_index = read_index;
    return rq;
  endfunction

  // Mostly observes of a small node population with a slowly moving clock, so
  // hits, evictions and time stamp ties all happen often.
  function automatic node_req_t random_request();
    node_req_t   rq;
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      now_ms = $urandom;
    end else begin
      now_ms = now_ms + $urandom_range(3);
    end
    rq.mode = MODE_OBSERVE;
    rq.address = node_pool[$urandom_range(POOL_SIZE - 1)];
    rq.signal = 8'($urandom);
    rq.time_ms = now_ms;
    rq.length = 8'($urandom_range(1) ? $urandom_range(8) : $urandom_range(255));
    rq.destination = 16'($urandom);
    rq.read_index = 4'($urandom);
    if (pick < 10) begin
      rq.mode = MODE_READ;
    end else if (pick == 10) begin
      rq.mode = MODE_CLEAR;
    end else if (pick == 11) begin
      rq.mode = MODE_UNUSED;
    end else if (pick < 17) begin
      rq.address = 48'({$urandom, $urandom});
    end
    return rq;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || in_valid_i || predicted_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = queued_requests.pop_front();
        in_valid_i <= 1'b1;
        mode_i <= next_req.mode;
        node_address_i <= next_req.address;
        signal_level_i <= next_req.signal;
        time_ms_i <= next_req.time_ms;
        packet_length_i <= next_req.length;
        destination_id_i <= next_req.destination;
        read_index_i <= next_req.read_index;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && (hold_off || $urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      taken_req = make_req(mode_i, node_address_i, signal_level_i, time_ms_i,
                           packet_length_i, destination_id_i, read_index_i);
      predicted_outcomes.push_back(predict_table_outcome(taken_req));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_outcomes.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual slot %0h",
                 $time, slot_o);
        fail_count++;
      end else begin
        got_outcome = predicted_outcomes.pop_front();
        check_field("slot", 64'(got_outcome.slot), 64'(slot_o));
        check_field("was_hit", 64'(got_outcome.was_hit), 64'(was_hit_o));
        check_field("was_evicted", 64'(got_outcome.was_evicted), 64'(was_evicted_o));
        check_field("entry_valid", 64'(got_outcome.entry_valid), 64'(entry_valid_o));
        check_field("entry_address", 64'(got_outcome.entry.address), 64'(entry_address_o));
        check_field("entry_signal", 64'(got_outcome.entry.signal),
                    64'($unsigned(entry_signal_o)));
        check_field("entry_last_seen", 64'(got_outcome.entry.last_seen),
                    64'(entry_last_seen_o));
        check_field("entry_packets", 64'(got_outcome.entry.packets), 64'(entry_packets_o));
        check_field("entry_short_id", 64'(got_outcome.entry.node_tag),
                    64'(entry_short_id_o));
        check_field("fill_count", 64'(got_outcome.fill_count), 64'(fill_count_o));
        check_field("total_packets", 64'(got_outcome.total_packets), 64'(total_packets_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    node_pool[0] = '0;
    node_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      node_pool[i] = 48'({$urandom, $urandom});
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extreme field values, the short id length boundary, reads of filled and
    // empty slots, and the unused mode.
    queued_requests.push_back(make_req(MODE_OBSERVE, 48'h0, 8'h80, 32'h0, 8'd0, 16'h0, 4'd0));
    queued_requests.push_back(make_req(MODE_OBSERVE, '1, 8'h7F, '1, 8'd255, '1, 4'd15));
    queued_requests.push_back(make_req(MODE_OBSERVE, 48'h0, 8'h05, 32'd7, 8'd4, 16'h1234,
                                       4'd0));
    queued_requests.push_back(make_req(MODE_OBSERVE, 48'h0, 8'hFF, 32'd7, 8'd5, 16'hBEEF,
                                       4'd0));
    queued_requests.push_back(make_req(MODE_READ, 48'h0, 8'h0, 32'h0, 8'd0, 16'h0, 4'd1));
    queued_requests.push_back(make_req(MODE_READ, 48'h0, 8'h0, 32'h0, 8'd0, 16'h0, 4'd15));
    queued_requests.push_back(make_req(MODE_UNUSED, '1, 8'h55, 32'd3, 8'd9, 16'h5A5A, 4'd3));
    // Fill the table with equal time stamps so the first eviction is a tie.
    for (int i = 2; i < NODE_SLOTS; i++) begin
      queued_requests.push_back(make_req(MODE_OBSERVE, 48'hA5A5_0000_1000 | i, 8'(i * 9),
                                         32'd7, 8'd6, 16'(i), 4'd0));
    end
    queued_requests.push_back(make_req(MODE_OBSERVE, 48'h1234_5678_9ABC, 8'h10, 32'd9, 8'd5,
                                       16'h0101, 4'd0));
    queued_requests.push_back(make_req(MODE_OBSERVE, 48'hCAFE_0000_0001, 8'h20, 32'd9, 8'd5,
                                       16'h0202, 4'd0));
    queued_requests.push_back(make_req(MODE_READ, 48'h0, 8'h0, 32'h0, 8'd0, 16'h0, 4'd0));
    queued_requests.push_back(make_req(MODE_CLEAR, 48'h0, 8'h0, 32'h0, 8'd0, 16'h0, 4'd0));
    queued_requests.push_back(make_req(MODE_READ, 48'h0, 8'h0, 32'h0, 8'd0, 16'h0, 4'd0));
    // An address still held beyond the fill count must miss after a clear.
    queued_requests.push_back(make_req(MODE_OBSERVE, 48'hA5A5_0000_1003, 8'h01, 32'd1,
                                       8'd5, 16'h0303, 4'd0));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 81 : (phase == 3) ? 17 : 0;
      stall_pct = (phase == 2) ? 81 : (phase == 3) ? 17 : 0;
      repeat (300) queued_requests.push_back(random_request());
      wait_drained();
    end

    // Long result hold-off while requests keep coming, so the input backs up.
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (100) queued_requests.push_back(random_request());
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
    wait_drained();

    repeat (2 * NODE_SLOTS + 8) @(posedge clk_i);
    if (fail_count == 0 && predicted_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
